// ===== rtl/core/tas_pkg.sv =====
// Shared types and constants for the thruster allocation block.
// No dependencies; the top level and the testbench import this package.
package tas_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_MATRIX = 2'd0,
    OP_LOAD_LIN    = 2'd1,
    OP_DEMAND      = 2'd2,
    OP_STOP        = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC,
    ST_LIN_RD,
    ST_LIN_MUL,
    ST_LIN_ADD,
    ST_CHECK,
    ST_SCL_RD,
    ST_SCL_MUL,
    ST_DIV,
    ST_DIV_WR,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [2:0]         thruster_index;
    logic [2:0]         axis_index;
    logic [1:0]         table_select;
    logic signed [31:0] coefficient;
    logic signed [31:0] demand_x;
    logic signed [31:0] demand_y;
    logic signed [31:0] demand_z;
    logic signed [31:0] demand_yaw;
    logic signed [31:0] demand_pitch;
    logic signed [31:0] demand_roll;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0]         thruster_number;
    logic signed [31:0] command;
    logic               scaled_down;
    logic               last;
  } thr_cmd_t;

  localparam int unsigned DemandFields = 6;
  localparam int unsigned LinEntries   = 4;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CfgAddrW     = 3;
  localparam logic [CfgAddrW-1:0] RegThrCount = 3'd0;
  localparam logic [CfgAddrW-1:0] RegMaxCmd   = 3'd4;

  localparam logic [1:0] SelPosSlope = 2'd0;
  localparam logic [1:0] SelNegSlope = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7fffffff;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/tas_if.sv =====
// Valid/ready channel interface with a generic payload type.
// Depends on nothing; payload structs come from tas_pkg.
interface tas_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tas_ram.sv =====
// Generic single-port write, single-port registered read RAM.
// No dependencies.
module tas_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/tas_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned 63/32 bits.
// No dependencies.
module tas_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [62:0] quotient_o
);

  logic [62:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[31:0], quo_q[62]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[61:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[61:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd62) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = busy_q && (cnt_q == 6'd62);
  assign quotient_o = quo_d;
endmodule

// ===== rtl/core/thruster_allocation_with_scaling.sv =====
// Thruster allocation top level: sequencer, shared multiplier, tables.
// Depends on tas_pkg, tas_if, tas_ram and tas_div.
//
// Usage: requests arrive on the in_ch sink channel, results leave on out_ch.
// A request carries an operation: a matrix or linearisation load writes one
// table entry and produces nothing; a demand or a stop produces one command
// per active thruster, thruster 0 first, last set on the final one.
// Flow: a load is taken and the block is ready again on the next cycle.
// A demand runs allocation and linearisation for each active thruster, then
// one check, and when scaling applies a scaling pass per thruster through
// the one shared multiplier and the bit-serial divider. Each command is then
// read from the command buffer and offered until the receiver takes it.
// A stop, or a demand while stopped, only takes the emit phase, one cycle per
// command while the receiver is ready. The block takes one request at a time
// and holds in_ch ready low until the last command is taken.
// Reset clears the stop latch and puts the registers at their reset values.
// The tables are cleared after reset by a pass over every table entry,
// during which no request is taken.
// If the receiver stalls, the current command holds until it is taken.
module thruster_allocation_with_scaling #(
  parameter int unsigned MAX_THRUSTERS = 8,
  parameter int unsigned AXIS_COUNT    = 6,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tas_if.sink                            in_ch,
  tas_if.source                          out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tas_pkg::CfgAddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tas_pkg::*;

  localparam int unsigned AllocDepth = MAX_THRUSTERS * AXIS_COUNT;
  localparam int unsigned LinDepth   = MAX_THRUSTERS * LinEntries;
  localparam int unsigned AW         = $clog2(AllocDepth);
  localparam int unsigned LW         = $clog2(LinDepth);
  localparam int unsigned TW         = $clog2(MAX_THRUSTERS + 1);
  localparam int unsigned XW         = $clog2(AXIS_COUNT + 1);
  localparam int unsigned ClrDepth   = (AllocDepth > LinDepth) ? AllocDepth : LinDepth;
  localparam int unsigned CW         = $clog2(ClrDepth + 1);

  // Configuration.
  logic [3:0]  thr_count_q;
  logic [30:0] max_cmd_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_count_q <= 4'd8;
      max_cmd_q   <= 31'd6553600;
    end else if (cfg_wr) begin
      if (paddr == RegThrCount) thr_count_q <= pwdata[3:0];
      else if (paddr == RegMaxCmd) max_cmd_q <= pwdata[30:0];
    end
  end
  always_comb begin
    case (paddr)
      RegThrCount: prdata = {28'd0, thr_count_q};
      RegMaxCmd:   prdata = {1'b0, max_cmd_q};
      default:     prdata = '0;
    endcase
  end

  logic [TW-1:0] n_act;
  always_comb begin
    if (thr_count_q == 4'd0) n_act = TW'(1);
    else if (32'(thr_count_q) > MAX_THRUSTERS) n_act = TW'(MAX_THRUSTERS);
    else n_act = TW'(thr_count_q);
  end

  // Clear pass after reset.
  logic          clr_q;
  logic [CW-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + CW'(1);
      if (32'(clr_cnt_q) == ClrDepth - 1) clr_q <= 1'b0;
    end
  end

  state_e state_q, state_d;
  logic   stopped_q, stopped_d;
  logic [TW-1:0] t_q, t_d;
  logic [XW-1:0] a_q, a_d;
  logic signed [31:0] dem_q [AXIS_COUNT];
  logic signed [71:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] cmd_q, cmd_d;
  logic [31:0]  largest_q, largest_d;
  logic         scaled_q, scaled_d;
  logic         neg_q, neg_d;

  // RAM hookups.
  logic          al_we, ln_we, cb_we;
  logic [AW-1:0] al_wa, al_ra;
  logic [LW-1:0] ln_wa, ln_ra;
  logic [31:0]   al_wd, ln_wd, cb_wd, al_rd, ln_rd, cb_rd;
  logic [$clog2(MAX_THRUSTERS)-1:0] cb_wa, cb_ra;

  tas_ram #(.Width(32), .Depth(AllocDepth)) u_alloc (
    .clk_i, .we_i(al_we), .waddr_i(al_wa), .wdata_i(al_wd),
    .raddr_i(al_ra), .rdata_o(al_rd));
  tas_ram #(.Width(32), .Depth(LinDepth)) u_lin (
    .clk_i, .we_i(ln_we), .waddr_i(ln_wa), .wdata_i(ln_wd),
    .raddr_i(ln_ra), .rdata_o(ln_rd));
  tas_ram #(.Width(32), .Depth(MAX_THRUSTERS)) u_cmd (
    .clk_i, .we_i(cb_we), .waddr_i(cb_wa), .wdata_i(cb_wd),
    .raddr_i(cb_ra), .rdata_o(cb_rd));

  // Divider for scaling.
  logic        div_start, div_done;
  logic [62:0] div_quo;
  logic        div_go_q;
  tas_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(prod_q[62:0]),
    .divisor_i(largest_q), .done_o(div_done), .quotient_o(div_quo));

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE) && !clr_q;

  logic [$clog2(MAX_THRUSTERS)-1:0] t_idx;
  assign t_idx = t_q[$clog2(MAX_THRUSTERS)-1:0];
  logic last_t;
  assign last_t = (t_q == n_act - TW'(1));

  // Shared multiplier: operands selected by state.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Matrix read data is registered, so the demand follows one column behind.
  logic [XW-1:0] a_prev;
  assign a_prev = (a_q == '0) ? '0 : a_q - XW'(1);
  logic signed [31:0] a_dem;
  assign a_dem = dem_q[a_prev[$clog2(AXIS_COUNT > 1 ? AXIS_COUNT : 2)-1:0]];

  logic signed [31:0] thrust;
  assign thrust = sat32(acc_q);
  logic [31:0] cmd_abs;
  assign cmd_abs = cb_rd[31] ? (~cb_rd + 32'd1) : cb_rd;
  logic signed [63:0] lin_sh;
  assign lin_sh = prod_q >>> FRAC_BITS;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.operation == OP_STOP ||
              (in_ch.data.operation == OP_DEMAND && stopped_q)) state_d = ST_EMIT;
          else if (in_ch.data.operation == OP_DEMAND) state_d = ST_MAC_RD;
        end
      end
      ST_MAC_RD:  state_d = ST_MAC;
      ST_MAC:     state_d = (32'(a_q) == AXIS_COUNT) ? ST_LIN_RD : ST_MAC;
      ST_LIN_RD:  state_d = ST_LIN_MUL;
      ST_LIN_MUL: state_d = ST_LIN_ADD;
      ST_LIN_ADD: state_d = last_t ? ST_CHECK : ST_MAC_RD;
      ST_CHECK:   state_d = (largest_q > {1'b0, max_cmd_q}) ? ST_SCL_RD : ST_EMIT_RD;
      ST_SCL_RD:  state_d = ST_SCL_MUL;
      ST_SCL_MUL: state_d = ST_DIV;
      ST_DIV:     state_d = div_done ? ST_DIV_WR : ST_DIV;
      ST_DIV_WR:  state_d = last_t ? ST_EMIT_RD : ST_SCL_RD;
      ST_EMIT_RD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ch.ready) state_d = last_t ? ST_IDLE : (stopped_q ? ST_EMIT : ST_EMIT_RD);
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    t_d = t_q; a_d = a_q; acc_d = acc_q; prod_d = prod_q; cmd_d = cmd_q;
    largest_d = largest_q; scaled_d = scaled_q; neg_d = neg_q; stopped_d = stopped_q;
    al_we = 1'b0; ln_we = 1'b0; cb_we = 1'b0;
    al_wa = in_ch.data.thruster_index * AW'(AXIS_COUNT) + AW'(in_ch.data.axis_index);
    al_wd = in_ch.data.coefficient;
    ln_wa = LW'({in_ch.data.thruster_index, in_ch.data.table_select});
    ln_wd = in_ch.data.coefficient;
    al_ra = AW'(t_idx) * AW'(AXIS_COUNT) + AW'(a_q);
    ln_ra = LW'({t_idx, thrust[31] ? SelNegSlope : SelPosSlope});
    cb_wa = t_idx; cb_wd = cmd_q; cb_ra = t_idx;
    mul_a = 33'(a_dem); mul_b = 33'($signed(al_rd));
    div_start = div_go_q;
    if (clr_q) begin
      al_we = (32'(clr_cnt_q) < AllocDepth);
      al_wa = AW'(clr_cnt_q); al_wd = '0;
      ln_we = (32'(clr_cnt_q) < LinDepth);
      ln_wa = LW'(clr_cnt_q); ln_wd = '0;
    end
    case (state_q)
      ST_IDLE: begin
        t_d = '0; a_d = '0; acc_d = '0; largest_d = '0; scaled_d = 1'b0;
        if (in_acc) begin
          case (in_ch.data.operation)
            OP_LOAD_MATRIX: al_we = (32'(in_ch.data.thruster_index) < MAX_THRUSTERS) &&
                                    (32'(in_ch.data.axis_index) < AXIS_COUNT);
            OP_LOAD_LIN:    ln_we = (32'(in_ch.data.thruster_index) < MAX_THRUSTERS);
            OP_STOP:        stopped_d = 1'b1;
            default:        ;
          endcase
        end
      end
      ST_MAC_RD: begin
        a_d = a_q + XW'(1);
      end
      ST_MAC: begin
        // Floor shift of each product, summed exactly.
        acc_d = acc_q + 72'(mul_p >>> FRAC_BITS);
        if (32'(a_q) != AXIS_COUNT) a_d = a_q + XW'(1);
      end
      ST_LIN_RD: begin
        neg_d = thrust[31];
        ln_ra = LW'({t_idx, thrust[31] ? SelNegSlope : SelPosSlope});
      end
      ST_LIN_MUL: begin
        mul_a = 33'(thrust); mul_b = 33'($signed(ln_rd));
        prod_d = mul_p[63:0];
        ln_ra = LW'({t_idx, neg_q ? SelNegSlope : SelPosSlope} + 1);
      end
      ST_LIN_ADD: begin
        if (acc_q == 72'sd0) cmd_d = '0;
        else cmd_d = sat32(72'(sat32(72'(lin_sh))) + 72'($signed(ln_rd)));
        cb_we = 1'b1;
        cb_wd = (acc_q == 72'sd0) ? 32'd0
              : sat32(72'(sat32(72'(lin_sh))) + 72'($signed(ln_rd)));
        if ((acc_q != 72'sd0)) begin
          cmd_d = cb_wd;
        end
        acc_d = '0; a_d = '0;
        if (!last_t) t_d = t_q + TW'(1);
      end
      ST_CHECK: begin
        t_d = '0;
        scaled_d = (largest_q > {1'b0, max_cmd_q});
      end
      ST_SCL_MUL: begin
        mul_a = {1'b0, cmd_abs};
        mul_b = {2'b00, max_cmd_q};
        prod_d = mul_p[63:0];
        neg_d = cb_rd[31];
      end
      ST_DIV: ;
      ST_DIV_WR: begin
        cb_we = 1'b1;
        cb_wd = neg_q ? (~div_quo[31:0] + 32'd1) : div_quo[31:0];
        if (!last_t) t_d = t_q + TW'(1);
        else t_d = '0;
      end
      ST_EMIT: begin
        if (out_ch.ready && !last_t) t_d = t_q + TW'(1);
      end
      default: ;
    endcase
  end

  // The divider loads the product on the cycle after it is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_go_q <= 1'b0;
    else div_go_q <= (state_q == ST_SCL_MUL);
  end

  // Track largest magnitude as unscaled commands are written.
  logic [31:0] wr_abs;
  assign wr_abs = cb_wd[31] ? (~cb_wd + 32'd1) : cb_wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      stopped_q <= 1'b0;
      t_q       <= '0;
      a_q       <= '0;
      scaled_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      stopped_q <= stopped_d;
      t_q       <= t_d;
      a_q       <= a_d;
      scaled_q  <= scaled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    cmd_q  <= cmd_d;
    neg_q  <= neg_d;
    if (state_q == ST_LIN_ADD && wr_abs > largest_q) largest_q <= wr_abs;
    else largest_q <= largest_d;
    if (in_acc && in_ch.data.operation == OP_DEMAND) begin
      dem_q[0] <= in_ch.data.demand_x;
      if (AXIS_COUNT > 1) dem_q[1 % AXIS_COUNT] <= in_ch.data.demand_y;
      if (AXIS_COUNT > 2) dem_q[2 % AXIS_COUNT] <= in_ch.data.demand_z;
      if (AXIS_COUNT > 3) dem_q[3 % AXIS_COUNT] <= in_ch.data.demand_yaw;
      if (AXIS_COUNT > 4) dem_q[4 % AXIS_COUNT] <= in_ch.data.demand_pitch;
      if (AXIS_COUNT > 5) dem_q[5 % AXIS_COUNT] <= in_ch.data.demand_roll;
    end
  end

  // Output: each command is read from the command buffer in the state before it is offered.
  assign out_ch.valid = (state_q == ST_EMIT);
  assign out_ch.data.thruster_number = 3'(t_q);
  assign out_ch.data.command     = stopped_q ? 32'sd0 : $signed(cb_rd);
  assign out_ch.data.scaled_down = stopped_q ? 1'b0 : scaled_q;
  assign out_ch.data.last        = last_t;
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the thruster allocation block: it loads the tables, sends force demands and
// stops, and checks every command against a local predictor of the allocation arithmetic.
// Depends on tas_pkg, tas_if and the block's top level.
module tb_top;
  import tas_pkg::*;

  typedef struct {
    alloc_req_t req;
    bit         zero_typed;
  } stim_row_t;

  localparam int NumThr  = 8;
  localparam int NumAxis = 6;
  localparam logic [CfgAddrW-1:0] RegCount = RegThrCount;
  localparam logic [CfgAddrW-1:0] RegMax   = RegMaxCmd;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  tas_if #(.payload_t(alloc_req_t)) req_if ();
  tas_if #(.payload_t(thr_cmd_t))   cmd_if ();

  thruster_allocation_with_scaling uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(req_if), .out_ch(cmd_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  logic signed [31:0] alloc_mat [NumThr*NumAxis];
  logic signed [31:0] lin_coef [NumThr*4];
  bit                 halted;
  logic [3:0]         cfg_count;
  logic [30:0]        cfg_max;
  thr_cmd_t           cmd_expected [$];

  int  errors, demands_sent, cmds_checked;
  int  tx_idle, rx_idle;
  bit  hold_req;
  int  hold_cnt;
  bit  cur_zero_typed;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Works out the commands one request causes and queues them.
  function automatic void predict_commands(alloc_req_t r, bit zero_typed);
    int        n;
    longint    thrust, c, largest;
    longint    cmds [NumThr];
    logic signed [31:0] dem [NumAxis];
    bit        scl;
    thr_cmd_t  e;
    n = (cfg_count == 0) ? 1 : (cfg_count > NumThr) ? NumThr : int'(cfg_count);
    if (r.operation == OP_LOAD_MATRIX) begin
      if (r.axis_index < NumAxis) alloc_mat[r.thruster_index*NumAxis + r.axis_index] = r.coefficient;
      return;
    end
    if (r.operation == OP_LOAD_LIN) begin
      lin_coef[r.thruster_index*4 + r.table_select] = r.coefficient;
      return;
    end
    if (r.operation == OP_STOP) halted = 1'b1;
    dem = '{r.demand_x, r.demand_y, r.demand_z, r.demand_yaw, r.demand_pitch, r.demand_roll};
    largest = 0;
    for (int t = 0; t < n; t++) begin
      thrust = 0;
      for (int a = 0; a < NumAxis; a++)
        thrust += (longint'(alloc_mat[t*NumAxis + a]) * longint'(dem[a])) >>> 16;
      thrust = clip32(thrust);
      c = 0;
      if (thrust > 0) begin
        c = clip32((thrust * longint'(lin_coef[t*4 + 0])) >>> 16);
        c = clip32(c + longint'(lin_coef[t*4 + 1]));
      end else if (thrust < 0) begin
        c = clip32((thrust * longint'(lin_coef[t*4 + 2])) >>> 16);
        c = clip32(c + longint'(lin_coef[t*4 + 3]));
      end
      if (halted) c = 0;
      cmds[t] = c;
      if ((c < 0 ? -c : c) > largest) largest = (c < 0 ? -c : c);
    end
    scl = !halted && (largest > longint'(cfg_max));
    for (int t = 0; t < n; t++) begin
      if (scl) cmds[t] = (cmds[t] * longint'(cfg_max)) / largest;
      e.thruster_number = t[2:0];
      e.command         = zero_typed ? 32'sd0 : cmds[t][31:0];
      e.scaled_down     = zero_typed ? 1'b0 : scl;
      e.last            = (t == n - 1);
      cmd_expected.push_back(e);
    end
  endfunction

  // Request acceptance feeds the predictor; accepted commands are checked in order.
  always @(posedge clk_i) begin
    thr_cmd_t e, got;
    if (rst_ni && req_if.valid && req_if.ready) begin
      predict_commands(req_if.data, cur_zero_typed);
      if (req_if.data.operation inside {OP_DEMAND, OP_STOP}) demands_sent++;
    end
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      got = cmd_if.data;
      if (cmd_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected command, expected none actual %p", $time, got);
      end else begin
        e = cmd_expected.pop_front();
        cmds_checked++;
        if (got.thruster_number !== e.thruster_number || got.command !== e.command ||
            got.scaled_down !== e.scaled_down || got.last !== e.last) begin
          errors++;
          $display("%0t: command mismatch expected %p actual %p", $time, e, got);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      cmd_if.ready <= 1'b0;
    end else begin
      cmd_if.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic apb_write(logic [CfgAddrW-1:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == RegCount) cfg_count = val[3:0];
    else cfg_max = val[30:0];
  endtask

  task automatic send_request(alloc_req_t r, bit zero_typed);
    while ($urandom_range(99) < tx_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    cur_zero_typed <= zero_typed;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (cmd_expected.size() != 0) @(posedge clk_i);
    // A trailing table load leaves nothing to wait for; give it time to land.
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return ($signed($urandom_range(0, 16)) - 8) <<< 16;
    endcase
  endfunction

  function automatic alloc_req_t mk_load(op_e op, int thr, int sel, logic signed [31:0] val);
    alloc_req_t r;
    r = '0;
    r.operation = op;
    r.thruster_index = thr[2:0];
    r.axis_index = sel[2:0];
    r.table_select = sel[1:0];
    r.coefficient = val;
    r.demand_x = $urandom;
    return r;
  endfunction

  function automatic alloc_req_t mk_demand(op_e op, logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, logic signed [31:0] rest);
    alloc_req_t r;
    r = '0;
    r.operation = op;
    r.coefficient = $urandom;
    r.thruster_index = 3'($urandom);
    r.axis_index = 3'($urandom);
    r.table_select = 2'($urandom);
    r.demand_x = x; r.demand_y = y; r.demand_z = z;
    r.demand_yaw = rest; r.demand_pitch = -rest; r.demand_roll = rest >>> 1;
    return r;
  endfunction

  function automatic alloc_req_t rand_request();
    int k;
    k = $urandom_range(99);
    if (k < 15) return mk_load(OP_LOAD_MATRIX, $urandom_range(7), $urandom_range(7), rand_word());
    if (k < 30) return mk_load(OP_LOAD_LIN, $urandom_range(7), $urandom_range(3), rand_word());
    return mk_demand(OP_DEMAND, rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  initial begin
    stim_row_t   directed [$];
    stim_row_t   ending [$];
    logic [3:0]  count_set [6];
    logic [31:0] max_set [6];
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_if.valid = 1'b0; req_if.data = '0;
    cmd_if.ready = 1'b0;
    cur_zero_typed = 1'b0;
    hold_req = 1'b0; hold_cnt = 0;
    errors = 0; demands_sent = 0; cmds_checked = 0;
    tx_idle = 29; rx_idle = 87;
    foreach (alloc_mat[i]) alloc_mat[i] = '0;
    foreach (lin_coef[i]) lin_coef[i] = '0;
    halted = 1'b0; cfg_count = 4'd8; cfg_max = 31'd6553600;
    count_set = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
    max_set   = '{32'd0, 32'h7fffffff, 32'd65536, 32'd6553600, 32'd1, 32'd300000000};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Cleared tables give zero commands.
    directed.push_back('{mk_demand(OP_DEMAND, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                   32'sh80000000), 1'b1});
    directed.push_back('{mk_load(OP_LOAD_MATRIX, 0, 0, 32'sh7fffffff), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_MATRIX, 0, 5, 32'sh80000000), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_MATRIX, 7, 3, 32'sh00010000), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_MATRIX, 1, 1, 32'shfffe0000), 1'b0});
    // Column indexes past the last axis are dropped.
    directed.push_back('{mk_load(OP_LOAD_MATRIX, 3, 6, 32'sh12345678), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_MATRIX, 2, 7, 32'sh7fffffff), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_LIN, 0, 0, 32'sh00010000), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_LIN, 0, 1, 32'sh7fffffff), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_LIN, 0, 2, 32'sh80000000), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_LIN, 0, 3, 32'shffffffff), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_LIN, 7, 0, 32'sh00020000), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_LIN, 7, 2, 32'shffff0000), 1'b0});
    directed.push_back('{mk_load(OP_LOAD_LIN, 1, 2, 32'sh00008000), 1'b0});
    directed.push_back('{mk_demand(OP_DEMAND, 32'sh00010000, 0, 0, 0), 1'b0});
    directed.push_back('{mk_demand(OP_DEMAND, 32'shffff0000, 0, 0, 0), 1'b0});
    directed.push_back('{mk_demand(OP_DEMAND, 0, 32'sh00030000, 0, 32'sh00050000), 1'b0});
    directed.push_back('{mk_demand(OP_DEMAND, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                                   32'sh80000000), 1'b0});
    directed.push_back('{mk_demand(OP_DEMAND, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                   32'sh7fffffff), 1'b0});
    directed.push_back('{mk_demand(OP_DEMAND, 0, 0, 0, 0), 1'b0});
    foreach (directed[i]) send_request(directed[i].req, directed[i].zero_typed);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      apb_write(RegCount, {28'd0, count_set[ph]});
      apb_write(RegMax, max_set[ph]);
      tx_idle = (ph < 2) ? 29 : (ph < 4) ? 87 : 0;
      rx_idle = (ph < 2) ? 87 : (ph < 4) ? 29 : 0;
      // The receiver stops for a long while so the block backs up and stalls its input.
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < 14; i++) send_request(rand_request(), 1'b0);
      wait_idle();
    end

    // Stop latches until reset, so it comes last.
    tx_idle = 0; rx_idle = 0;
    ending.push_back('{mk_demand(OP_STOP, 32'sh00010000, 0, 0, 0), 1'b1});
    ending.push_back('{mk_demand(OP_DEMAND, 32'sh00070000, 32'sh7fffffff, 0, 0), 1'b1});
    ending.push_back('{mk_load(OP_LOAD_LIN, 2, 1, 32'sh00400000), 1'b0});
    ending.push_back('{mk_demand(OP_DEMAND, 32'sh80000000, 0, 32'sh00010000, 0), 1'b1});
    ending.push_back('{mk_demand(OP_STOP, 0, 0, 0, 0), 1'b1});
    foreach (ending[i]) send_request(ending[i].req, ending[i].zero_typed);
    wait_idle();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d demand and stop requests with %0d commands checked, over six",
             demands_sent, cmds_checked);
    $display("register settings including zero and full-scale limits and the stopped state.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tas_pkg.sv
rtl/core/tas_if.sv
rtl/core/tas_ram.sv
rtl/core/tas_div.sv
rtl/core/thruster_allocation_with_scaling.sv
tb/sv/tb_top.sv
